// ----- rtl/core/pcs_pkg.sv -----
package pcs_pkg;

   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 32;

   localparam int X_W      = 6;
   localparam int Y_W      = 5;
   localparam int ADDR_W   = X_W + Y_W;
   localparam int DEPTH    = GRID_WIDTH << Y_W;
   localparam int CELL_W   = 2;
   localparam int DRAW_W   = 16;
   localparam int THRESH_W = 17;

   localparam logic [X_W-1:0] X_LAST   = X_W'(GRID_WIDTH - 1);
   localparam logic [Y_W-1:0] Y_LAST   = Y_W'(GRID_HEIGHT - 1);
   localparam logic [X_W-1:0] CENTER_X = X_W'(GRID_WIDTH / 2);
   localparam logic [Y_W-1:0] CENTER_Y = Y_W'(GRID_HEIGHT / 2);

   localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd32768;

   localparam logic [CELL_W-1:0] CELL_OFF        = 2'd0;
   localparam logic [CELL_W-1:0] CELL_ON         = 2'd1;
   localparam logic [CELL_W-1:0] CELL_UNASSIGNED = 2'd2;

   localparam logic CMD_CLEAR = 1'b0;
   localparam logic CMD_VISIT = 1'b1;

   typedef struct packed {
      logic              command;
      logic [DRAW_W-1:0] random_draw;
   } pcs_req_type;

   typedef struct packed {
      logic [X_W-1:0]    cell_x;
      logic [Y_W-1:0]    cell_y;
      logic [CELL_W-1:0] cell_state;
      logic              cell_assigned;
      logic              sweep_end;
      logic              sweep_changed;
   } pcs_rsp_type;

endpackage

// ----- rtl/core/pcs_ram.sv -----
module pcs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic                     rd_en_b,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] data_a_ff;
   logic [WIDTH-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         data_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

// ----- rtl/core/percolation_cluster_sweep.sv -----
// Grows a site-percolation cluster on a 64 x 32 toroidal grid held in a grid memory with one
// write and two read ports. A clear transaction completes in the clear state. A visit reads
// the cell and its upper neighbor on the two read ports as it is accepted, then its left and
// right neighbors, then writes back; the next transaction enters in the write-back cycle. On
// the first row of each column the lower neighbor (the wrapped last row) needs its own read
// before those. Elsewhere it is the previous visit's result, kept in a register. The
// response is registered and appears in the cycle after the work is done; a held response
// stalls the write-back of a visit and the end of a clear. There is no clearing pass: during
// the first sweep after reset or a clear, every visit writes its cell, and cells the scan has
// not reached yet read as unassigned (the centre as on). The on threshold must be written
// through the csr port only while no transaction is in flight; the block does not enforce this.
module percolation_cluster_sweep (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pcs_pkg::pcs_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pcs_pkg::pcs_rsp_type            rsp_data,
   input  logic                            csr_write_enable,
   input  logic [pcs_pkg::THRESH_W-1:0]    csr_write_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_CUR   = 5'b00100,
      ST_DOWN  = 5'b01000,
      ST_LR    = 5'b10000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   logic [pcs_pkg::X_W-1:0]      scan_x_ff, scan_x_in;
   logic [pcs_pkg::Y_W-1:0]      scan_y_ff, scan_y_in;
   logic                         any_change_ff, any_change_in;
   logic                         filled_ff, filled_in;
   logic [pcs_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic [pcs_pkg::DRAW_W-1:0]   draw_ff, draw_in;
   logic [pcs_pkg::CELL_W-1:0]   cur_ff, cur_in;
   logic [pcs_pkg::CELL_W-1:0]   up_ff, up_in;
   logic [pcs_pkg::CELL_W-1:0]   down_ff, down_in;
   logic [pcs_pkg::CELL_W-1:0]   prev_ff, prev_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pcs_pkg::pcs_rsp_type         rsp_data_ff, rsp_data_in;

   logic                         rd_en_a, rd_en_b;
   logic [pcs_pkg::ADDR_W-1:0]   rd_addr_a, rd_addr_b;
   logic [pcs_pkg::CELL_W-1:0]   rd_data_a, rd_data_b;
   logic                         wr_en;
   logic [pcs_pkg::ADDR_W-1:0]   wr_addr;
   logic [pcs_pkg::CELL_W-1:0]   wr_data;

   logic                         out_free;
   logic                         done_fire;
   logic                         accept;
   logic                         first_sweep;
   logic [pcs_pkg::X_W-1:0]      x_left, x_right;
   logic [pcs_pkg::Y_W-1:0]      y_up;
   logic [pcs_pkg::CELL_W-1:0]   cur_eff, up_eff, down_eff, left_eff, right_eff;
   logic                         near_on;
   logic                         do_assign;
   logic                         draw_on;
   logic [pcs_pkg::CELL_W-1:0]   new_state;
   logic                         at_end;

   function automatic logic [pcs_pkg::X_W-1:0] x_dec(input logic [pcs_pkg::X_W-1:0] x);
      return (x == '0) ? pcs_pkg::X_LAST : x - 1'b1;
   endfunction

   function automatic logic [pcs_pkg::X_W-1:0] x_inc(input logic [pcs_pkg::X_W-1:0] x);
      return (x == pcs_pkg::X_LAST) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [pcs_pkg::Y_W-1:0] y_inc(input logic [pcs_pkg::Y_W-1:0] y);
      return (y == pcs_pkg::Y_LAST) ? '0 : y + 1'b1;
   endfunction

   // value of a cell that has not been written since the last clear
   function automatic logic [pcs_pkg::CELL_W-1:0] seed_value(
      input logic [pcs_pkg::X_W-1:0] x,
      input logic [pcs_pkg::Y_W-1:0] y
   );
      return (x == pcs_pkg::CENTER_X && y == pcs_pkg::CENTER_Y) ?
             pcs_pkg::CELL_ON : pcs_pkg::CELL_UNASSIGNED;
   endfunction

   pcs_ram #(
      .WIDTH (pcs_pkg::CELL_W),
      .DEPTH (pcs_pkg::DEPTH)
   ) u_grid_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en_a   (rd_en_a),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_en_b   (rd_en_b),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign done_fire = out_free && (state_ff == ST_CLEAR || state_ff == ST_LR);
   assign req_ready = (state_ff == ST_IDLE) || done_fire;
   assign accept    = req_valid && req_ready;

   // neighbor evaluation for the visit in flight
   always_comb begin
      first_sweep = !filled_ff;
      x_left      = x_dec(scan_x_ff);
      x_right     = x_inc(scan_x_ff);
      y_up        = y_inc(scan_y_ff);

      // ahead of the scan in the first sweep means not yet written
      cur_eff   = first_sweep ? seed_value(scan_x_ff, scan_y_ff) : cur_ff;
      up_eff    = (first_sweep && scan_y_ff != pcs_pkg::Y_LAST) ?
                  seed_value(scan_x_ff, y_up) : up_ff;
      if (scan_y_ff != '0) begin
         down_eff = prev_ff;
      end else begin
         down_eff = first_sweep ? seed_value(scan_x_ff, pcs_pkg::Y_LAST) : down_ff;
      end
      left_eff  = (first_sweep && scan_x_ff == '0) ?
                  seed_value(x_left, scan_y_ff) : rd_data_a;
      right_eff = (first_sweep && scan_x_ff != pcs_pkg::X_LAST) ?
                  seed_value(x_right, scan_y_ff) : rd_data_b;

      near_on   = (up_eff == pcs_pkg::CELL_ON) || (down_eff == pcs_pkg::CELL_ON) ||
                  (left_eff == pcs_pkg::CELL_ON) || (right_eff == pcs_pkg::CELL_ON);
      do_assign = (cur_eff == pcs_pkg::CELL_UNASSIGNED) && near_on;
      draw_on   = {1'b0, draw_ff} < thresh_ff;
      if (do_assign) begin
         new_state = draw_on ? pcs_pkg::CELL_ON : pcs_pkg::CELL_OFF;
      end else begin
         new_state = cur_eff;
      end
      at_end = (scan_x_ff == pcs_pkg::X_LAST) && (scan_y_ff == pcs_pkg::Y_LAST);
   end

   // scan position, sweep flags and response
   always_comb begin
      scan_x_in     = scan_x_ff;
      scan_y_in     = scan_y_ff;
      any_change_in = any_change_ff;
      filled_in     = filled_ff;
      prev_in       = prev_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      thresh_in     = csr_write_enable ? csr_write_data : thresh_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_fire) begin
         rsp_valid_in = 1'b1;
         if (state_ff == ST_CLEAR) begin
            scan_x_in                 = '0;
            scan_y_in                 = '0;
            any_change_in             = 1'b0;
            filled_in                 = 1'b0;
            rsp_data_in.cell_x        = pcs_pkg::CENTER_X;
            rsp_data_in.cell_y        = pcs_pkg::CENTER_Y;
            rsp_data_in.cell_state    = pcs_pkg::CELL_ON;
            rsp_data_in.cell_assigned = 1'b0;
            rsp_data_in.sweep_end     = 1'b0;
            rsp_data_in.sweep_changed = 1'b0;
         end else begin
            scan_y_in = y_inc(scan_y_ff);
            if (scan_y_ff == pcs_pkg::Y_LAST) begin
               scan_x_in = x_inc(scan_x_ff);
            end
            any_change_in             = at_end ? 1'b0 : (any_change_ff || do_assign);
            filled_in                 = filled_ff || at_end;
            prev_in                   = new_state;
            rsp_data_in.cell_x        = scan_x_ff;
            rsp_data_in.cell_y        = scan_y_ff;
            rsp_data_in.cell_state    = new_state;
            rsp_data_in.cell_assigned = do_assign;
            rsp_data_in.sweep_end     = at_end;
            rsp_data_in.sweep_changed = at_end && (any_change_ff || do_assign);
         end
      end
   end

   // read sequencing
   always_comb begin
      state_in  = state_ff;
      rd_en_a   = 1'b0;
      rd_en_b   = 1'b0;
      rd_addr_a = {scan_x_in, scan_y_in};
      rd_addr_b = {scan_x_in, y_inc(scan_y_in)};
      draw_in   = draw_ff;
      cur_in    = cur_ff;
      up_in     = up_ff;
      down_in   = down_ff;

      if (accept) begin
         draw_in = req_data.random_draw;
      end

      unique case (state_ff) inside
         ST_CUR: begin
            cur_in = rd_data_a;
            up_in  = rd_data_b;
            if (scan_y_ff == '0) begin
               rd_en_a   = 1'b1;
               rd_addr_a = {scan_x_ff, pcs_pkg::Y_LAST};
               state_in  = ST_DOWN;
            end else begin
               rd_en_a   = 1'b1;
               rd_en_b   = 1'b1;
               rd_addr_a = {x_left, scan_y_ff};
               rd_addr_b = {x_right, scan_y_ff};
               state_in  = ST_LR;
            end
         end
         ST_DOWN: begin
            down_in   = rd_data_a;
            rd_en_a   = 1'b1;
            rd_en_b   = 1'b1;
            rd_addr_a = {x_left, scan_y_ff};
            rd_addr_b = {x_right, scan_y_ff};
            state_in  = ST_LR;
         end
         ST_IDLE, ST_CLEAR, ST_LR: begin
            if (done_fire) begin
               state_in = ST_IDLE;
            end
            // next transaction issues its first reads at the updated scan position
            if (accept) begin
               if (req_data.command == pcs_pkg::CMD_VISIT) begin
                  rd_en_a  = 1'b1;
                  rd_en_b  = 1'b1;
                  state_in = ST_CUR;
               end else begin
                  state_in = ST_CLEAR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wr_en   = done_fire && (state_ff == ST_LR) && (do_assign || first_sweep);
   assign wr_addr = {scan_x_ff, scan_y_ff};
   assign wr_data = new_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_x_ff     <= '0;
         scan_y_ff     <= '0;
         any_change_ff <= 1'b0;
         filled_ff     <= 1'b0;
         thresh_ff     <= pcs_pkg::THRESH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_x_ff     <= scan_x_in;
         scan_y_ff     <= scan_y_in;
         any_change_ff <= any_change_in;
         filled_ff     <= filled_in;
         thresh_ff     <= thresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      draw_ff     <= draw_in;
      cur_ff      <= cur_in;
      up_ff       <= up_in;
      down_ff     <= down_in;
      prev_ff     <= prev_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/pcs_checker.sv -----
module pcs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input pcs_pkg::pcs_rsp_type rsp_data
);

   // a response cannot survive reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sweep_changed |-> rsp_data.sweep_end)
      else $error("sweep change flag outside sweep end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sweep_end |->
         rsp_data.cell_x == pcs_pkg::X_LAST && rsp_data.cell_y == pcs_pkg::Y_LAST)
      else $error("sweep end reported away from the last cell");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cell_assigned |->
         rsp_data.cell_state == pcs_pkg::CELL_ON || rsp_data.cell_state == pcs_pkg::CELL_OFF)
      else $error("assigned cell left unassigned");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind percolation_cluster_sweep pcs_checker u_pcs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- bench/percolation_cluster_sweep_checker.sv -----
module percolation_cluster_sweep_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  pcs_pkg::pcs_req_type         req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  pcs_pkg::pcs_rsp_type         rsp_data,
   input  logic                         csr_write_enable,
   input  logic [pcs_pkg::THRESH_W-1:0] csr_write_data,
   output int                           pending_count,
   output int                           error_count
);

   logic [pcs_pkg::CELL_W-1:0]   cluster_grid [pcs_pkg::GRID_WIDTH][pcs_pkg::GRID_HEIGHT];
   logic [pcs_pkg::X_W-1:0]      scan_col;
   logic [pcs_pkg::Y_W-1:0]      scan_row;
   logic                         sweep_grew;
   logic [pcs_pkg::THRESH_W-1:0] on_level;
   pcs_pkg::pcs_rsp_type         expected_cells [$];
   int                           mismatch_total = 0;

   assign error_count = mismatch_total;

   function automatic void seed_cluster();
      for (int x = 0; x < pcs_pkg::GRID_WIDTH; x++)
         for (int y = 0; y < pcs_pkg::GRID_HEIGHT; y++)
            cluster_grid[x][y] = pcs_pkg::CELL_UNASSIGNED;
      cluster_grid[pcs_pkg::CENTER_X][pcs_pkg::CENTER_Y] = pcs_pkg::CELL_ON;
      scan_col   = '0;
      scan_row   = '0;
      sweep_grew = 1'b0;
   endfunction

   function automatic pcs_pkg::pcs_rsp_type grow_cell(input pcs_pkg::pcs_req_type item);
      pcs_pkg::pcs_rsp_type result;
      int                   x;
      int                   y;
      logic                 touches_on;
      result = '0;
      if (item.command == pcs_pkg::CMD_CLEAR) begin
         seed_cluster();
         result.cell_x     = pcs_pkg::CENTER_X;
         result.cell_y     = pcs_pkg::CENTER_Y;
         result.cell_state = pcs_pkg::CELL_ON;
         return result;
      end
      x = scan_col;
      y = scan_row;
      result.cell_x     = scan_col;
      result.cell_y     = scan_row;
      result.cell_state = cluster_grid[x][y];
      if (result.cell_state == pcs_pkg::CELL_UNASSIGNED) begin
         // four neighbors on a torus
         touches_on =
            cluster_grid[(x + 1) % pcs_pkg::GRID_WIDTH][y] == pcs_pkg::CELL_ON
            || cluster_grid[(x + pcs_pkg::GRID_WIDTH - 1) % pcs_pkg::GRID_WIDTH][y]
               == pcs_pkg::CELL_ON
            || cluster_grid[x][(y + 1) % pcs_pkg::GRID_HEIGHT] == pcs_pkg::CELL_ON
            || cluster_grid[x][(y + pcs_pkg::GRID_HEIGHT - 1) % pcs_pkg::GRID_HEIGHT]
               == pcs_pkg::CELL_ON;
         if (touches_on) begin
            result.cell_state    = (item.random_draw < on_level) ?
                                   pcs_pkg::CELL_ON : pcs_pkg::CELL_OFF;
            result.cell_assigned = 1'b1;
            cluster_grid[x][y]   = result.cell_state;
            sweep_grew           = 1'b1;
         end
      end
      if (scan_row == pcs_pkg::Y_LAST) begin
         scan_row = '0;
         if (scan_col == pcs_pkg::X_LAST) begin
            scan_col             = '0;
            result.sweep_end     = 1'b1;
            result.sweep_changed = sweep_grew;
            sweep_grew           = 1'b0;
         end else begin
            scan_col = scan_col + 1'b1;
         end
      end else begin
         scan_row = scan_row + 1'b1;
      end
      return result;
   endfunction

   always @(posedge clock) begin
      pcs_pkg::pcs_rsp_type want;
      if (reset) begin
         seed_cluster();
         on_level = pcs_pkg::THRESH_RESET;
         expected_cells.delete();
      end else begin
         if (csr_write_enable) on_level = csr_write_data;
         if (req_valid && req_ready) expected_cells.push_back(grow_cell(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               $display("%0t: unexpected cell transaction x=%0d y=%0d state=%0d",
                        $time, rsp_data.cell_x, rsp_data.cell_y, rsp_data.cell_state);
               mismatch_total++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_data !== want) begin
                  $display({"%0t: cell mismatch expected x=%0d y=%0d state=%0d asg=%b ",
                            "end=%b chg=%b, actual x=%0d y=%0d state=%0d asg=%b end=%b chg=%b"},
                           $time, want.cell_x, want.cell_y, want.cell_state,
                           want.cell_assigned, want.sweep_end, want.sweep_changed,
                           rsp_data.cell_x, rsp_data.cell_y, rsp_data.cell_state,
                           rsp_data.cell_assigned, rsp_data.sweep_end, rsp_data.sweep_changed);
                  mismatch_total++;
               end
            end
         end
      end
      pending_count <= expected_cells.size();
   end

endmodule

// ----- bench/percolation_cluster_sweep_tb.sv -----
module percolation_cluster_sweep_tb;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef logic [pcs_pkg::THRESH_W-1:0] level_type;
   typedef logic [pcs_pkg::DRAW_W-1:0]   draw_type;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_ready;
   pcs_pkg::pcs_req_type         req_data         = '0;
   logic                         rsp_valid;
   logic                         rsp_ready        = 1'b0;
   pcs_pkg::pcs_rsp_type         rsp_data;
   logic                         csr_write_enable = 1'b0;
   logic [pcs_pkg::THRESH_W-1:0] csr_write_data   = '0;

   int                           pending_count;
   int                           error_count;
   int                           idle_pct      = 0;
   int                           stall_pct     = 0;
   int                           hold_requests = 0;
   int                           holds_served  = 0;
   int                           hold_left     = 0;
   logic [pcs_pkg::THRESH_W-1:0] draw_level    = pcs_pkg::THRESH_RESET;

   always #4 clock = ~clock;

   percolation_cluster_sweep u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   percolation_cluster_sweep_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending_count    (pending_count),
      .error_count      (error_count)
   );

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_ready    <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      idle_pct  = (mode == IDLE_SENDER)   ? 67 : (mode == IDLE_BOTH) ? 19 : 0;
      stall_pct = (mode == IDLE_RECEIVER) ? 67 : (mode == IDLE_BOTH) ? 19 : 0;
   endtask

   task automatic offer(input logic cmd, input logic [pcs_pkg::DRAW_W-1:0] draw);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, random_draw: draw};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [pcs_pkg::THRESH_W-1:0] level);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= level;
      draw_level       = level;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic sweep_visits(input int count, input int clear_odds);
      logic [pcs_pkg::DRAW_W-1:0] draw;
      for (int i = 0; i < count; i++) begin
         // bias draws toward the threshold edge and the field extremes
         case ($urandom_range(7))
            0: draw = '0;
            1: draw = '1;
            2: draw = draw_level[pcs_pkg::DRAW_W-1:0];
            3: draw = draw_level[pcs_pkg::DRAW_W-1:0] - 1'b1;
            default: draw = draw_type'($urandom);
         endcase
         if (clear_odds != 0 && $urandom_range(clear_odds - 1) == 0)
            offer(pcs_pkg::CMD_CLEAR, draw);
         else
            offer(pcs_pkg::CMD_VISIT, draw);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_idle(IDLE_NONE);

      // directed: both commands, draw extremes, reset and extreme thresholds
      offer(pcs_pkg::CMD_VISIT, '0);
      offer(pcs_pkg::CMD_VISIT, '1);
      offer(pcs_pkg::CMD_CLEAR, '1);
      offer(pcs_pkg::CMD_VISIT, 16'h5555);
      offer(pcs_pkg::CMD_VISIT, 16'hAAAA);
      write_threshold(17'd0);
      offer(pcs_pkg::CMD_VISIT, '0);
      offer(pcs_pkg::CMD_CLEAR, '0);
      offer(pcs_pkg::CMD_VISIT, '1);
      write_threshold(17'd65536);
      offer(pcs_pkg::CMD_VISIT, '1);
      offer(pcs_pkg::CMD_VISIT, 16'h8000);
      offer(pcs_pkg::CMD_VISIT, 16'h7FFF);
      offer(pcs_pkg::CMD_CLEAR, 16'h1234);

      // one long scan from a fresh seed; it reaches the seeded center near its sixth stretch
      write_threshold(17'd0);
      offer(pcs_pkg::CMD_CLEAR, draw_type'($urandom));
      sweep_visits(205, 0);
      write_threshold(level_type'($urandom_range(65536)));
      set_idle(IDLE_SENDER);
      sweep_visits(205, 0);
      set_idle(IDLE_RECEIVER);
      sweep_visits(205, 0);
      set_idle(IDLE_BOTH);
      sweep_visits(205, 0);
      // around the center column: full growth, with a long receiver hold-off
      // while the sender keeps pushing
      write_threshold(17'd65536);
      set_idle(IDLE_NONE);
      hold_requests = hold_requests + 1;
      sweep_visits(205, 0);
      write_threshold(level_type'($urandom_range(65536)));
      set_idle(IDLE_SENDER);
      sweep_visits(205, 0);

      // noise: frequent clears
      write_threshold(17'd65535);
      set_idle(IDLE_RECEIVER);
      sweep_visits(150, 12);
      write_threshold(level_type'($urandom_range(65536)));
      set_idle(IDLE_BOTH);
      sweep_visits(150, 12);

      drain();
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
